// ----- sv/lsti_pkg.sv -----
// Shared constants, types and the log2 fraction ROM of the log-spaced table interpolator.
package lsti_pkg;

  localparam int VALUE_W     = 32;
  localparam int ENERGY_W    = 32;
  localparam int ENTRY_IDX_W = 7;
  localparam int SCALE_W     = 24;
  localparam int SCALE_FRAC  = 20;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd4464217;

  localparam int TABLE_ENTRIES = 100;
  localparam int LAST_ENTRY    = TABLE_ENTRIES - 1;
  localparam int ADDR_W        = $clog2(TABLE_ENTRIES);

  localparam int FRAC_BITS  = 16;
  localparam int POS_W      = 5;
  localparam int ONE_EV_POS = 8;
  localparam int LOG_INT_W  = 5;
  localparam int LG_W       = LOG_INT_W + FRAC_BITS;
  localparam int S_W        = LG_W + SCALE_W;
  localparam int SQ_W       = S_W - SCALE_FRAC;
  localparam int L_W        = SQ_W - FRAC_BITS;

  localparam int ROM_FRAC    = 24;
  localparam int ROM_ENTRIES = 65;
  localparam int ROM_IDX_W   = 7;
  localparam int SEG_W       = 6;
  localparam int REM_W       = 25;

  localparam int PROD_W = VALUE_W + 1 + SQ_W + 1;
  localparam int V_W    = PROD_W - FRAC_BITS + 1;

  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int FRONT_STAGES = 7;

  localparam logic CMD_QUERY = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic                   is_wr;
    logic                   zero;
    logic [ENTRY_IDX_W-1:0] idx;
    logic [VALUE_W-1:0]     val;
  } front_meta_t;

  typedef struct packed {
    logic                   is_wr;
    logic                   zero;
    logic                   ext;
    logic [ADDR_W-1:0]      addr0;
    logic [ADDR_W-1:0]      addr1;
    logic [SQ_W-1:0]        mult;
    logic [ENTRY_IDX_W-1:0] wr_idx;
    logic [VALUE_W-1:0]     wr_val;
  } q_entry_t;

  typedef logic [ROM_FRAC:0] log_rom_t [ROM_ENTRIES];

  // log2(1 + i/64) in Q1.24 by repeated squaring, last entry exactly one
  function automatic log_rom_t build_log_rom();
    log_rom_t        rom;
    logic [63:0]     y;
    logic [63:0]     y2;
    logic [ROM_FRAC:0] r;
    for (int i = 0; i < ROM_ENTRIES; i++) begin
      if (i == ROM_ENTRIES - 1) begin
        rom[i] = (ROM_FRAC+1)'(1) << ROM_FRAC;
      end else begin
        y = 64'(64 + i) << 25;
        r = '0;
        for (int k = 0; k < ROM_FRAC; k++) begin
          y2 = y * y;
          r  = {r[ROM_FRAC-1:0], 1'b0};
          if (y2[63]) begin
            r[0] = 1'b1;
            y    = y2 >> 32;
          end else begin
            y = y2 >> 31;
          end
        end
        rom[i] = r;
      end
    end
    return rom;
  endfunction

  localparam log_rom_t LOG_ROM = build_log_rom();

endpackage

// ----- sv/lsti_front.sv -----
// Front pipeline: accepts transactions, computes the table position of queries, feeds the queue.
module lsti_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            cmd_i,
  input  logic [lsti_pkg::ENERGY_W-1:0]   energy_i,
  input  logic [lsti_pkg::ENTRY_IDX_W-1:0] entry_index_i,
  input  logic [lsti_pkg::VALUE_W-1:0]    entry_value_i,
  input  logic [lsti_pkg::SCALE_W-1:0]    index_scale_i,
  input  logic                            pop_i,
  output logic                            push_o,
  output lsti_pkg::q_entry_t              push_data_o
);
  import lsti_pkg::*;

  logic                    accept;
  logic [FIFO_CNT_W-1:0]   reserved_q, reserved_d;
  logic [FRONT_STAGES-1:0] vld_q, vld_d;

  front_meta_t meta_in;
  front_meta_t meta_q [FRONT_STAGES];

  logic [ENERGY_W-1:0] e1_q, e2_q;
  logic [POS_W-1:0]    p2_d, p2_q;

  logic [POS_W-1:0]    sh3;
  logic [ENERGY_W-1:0] xs3;
  logic [SEG_W-1:0]    j3_q;
  logic [REM_W-1:0]    rem3_q, rem4_q;
  logic [POS_W-1:0]    p8_3_q, p8_4_q, p8_5_q;

  logic [ROM_FRAC:0]   r0_full, r1_full, dr_full;
  logic [ROM_FRAC-1:0] r0_4_q, dr4_q, r0_5_q, ph5_q;
  logic [ROM_FRAC+REM_W-1:0] pr5;

  logic [ROM_FRAC-1:0] frac6;
  logic [LG_W-1:0]     lg6_q;
  logic [S_W-1:0]      s7;
  logic [SQ_W-1:0]     sq7_q;

  logic [L_W-1:0]       lpos;
  logic [FRAC_BITS-1:0] fpos;
  logic                 ext;

  // admit only when the queue has room for everything already in flight
  assign in_ready_o = reserved_q < FIFO_CNT_W'(FIFO_DEPTH);
  assign accept     = in_valid_i && in_ready_o;
  assign reserved_d = reserved_q + FIFO_CNT_W'(accept) - FIFO_CNT_W'(pop_i);
  assign vld_d      = {vld_q[FRONT_STAGES-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reserved_q <= '0;
      vld_q      <= '0;
    end else begin
      reserved_q <= reserved_d;
      vld_q      <= vld_d;
    end
  end

  // flag energies below one eV on entry
  always_comb begin
    meta_in.is_wr = (cmd_i == CMD_WRITE);
    meta_in.zero  = (energy_i[ENERGY_W-1:ONE_EV_POS] == '0);
    meta_in.idx   = entry_index_i;
    meta_in.val   = entry_value_i;
  end

  // leading-one search above the one-eV point
  always_comb begin
    p2_d = POS_W'(ONE_EV_POS);
    for (int i = ONE_EV_POS; i < ENERGY_W; i++) begin
      if (e1_q[i]) p2_d = POS_W'(i);
    end
  end

  // normalize: drop the leading one, split into segment and remainder
  assign sh3 = POS_W'(ENERGY_W - 1) - p2_q;
  assign xs3 = e2_q << sh3;

  assign r0_full = LOG_ROM[{1'b0, j3_q}];
  assign r1_full = LOG_ROM[{1'b0, j3_q} + ROM_IDX_W'(1)];
  assign dr_full = r1_full - r0_full;

  assign pr5   = (ROM_FRAC+REM_W)'(dr4_q) * (ROM_FRAC+REM_W)'(rem4_q);
  assign frac6 = r0_5_q + ph5_q;
  assign s7    = S_W'(lg6_q) * S_W'(index_scale_i);

  always_ff @(posedge clk_i) begin
    meta_q[0]       <= meta_in;
    e1_q            <= energy_i;

    meta_q[1]       <= meta_q[0];
    e2_q            <= e1_q;
    p2_q            <= p2_d;

    meta_q[2]       <= meta_q[1];
    j3_q            <= xs3[ENERGY_W-2 -: SEG_W];
    rem3_q          <= xs3[REM_W-1:0];
    p8_3_q          <= p2_q - POS_W'(ONE_EV_POS);

    meta_q[3]       <= meta_q[2];
    r0_4_q          <= r0_full[ROM_FRAC-1:0];
    dr4_q           <= dr_full[ROM_FRAC-1:0];
    rem4_q          <= rem3_q;
    p8_4_q          <= p8_3_q;

    meta_q[4]       <= meta_q[3];
    r0_5_q          <= r0_4_q;
    ph5_q           <= pr5[ROM_FRAC+REM_W-1:REM_W];
    p8_5_q          <= p8_4_q;

    meta_q[5]       <= meta_q[4];
    lg6_q           <= {p8_5_q, frac6[ROM_FRAC-1 -: FRAC_BITS]};

    meta_q[6]       <= meta_q[5];
    sq7_q           <= s7[S_W-1:SCALE_FRAC];
  end

  // classify: interpolate inside the table, extrapolate from the last pair
  assign lpos = sq7_q[SQ_W-1:FRAC_BITS];
  assign fpos = sq7_q[FRAC_BITS-1:0];
  assign ext  = lpos >= L_W'(LAST_ENTRY);

  assign push_o = vld_q[FRONT_STAGES-1];

  always_comb begin
    push_data_o.is_wr  = meta_q[FRONT_STAGES-1].is_wr;
    push_data_o.zero   = meta_q[FRONT_STAGES-1].zero;
    push_data_o.ext    = ext;
    push_data_o.wr_idx = meta_q[FRONT_STAGES-1].idx;
    push_data_o.wr_val = meta_q[FRONT_STAGES-1].val;
    if (ext) begin
      push_data_o.addr0 = ADDR_W'(LAST_ENTRY);
      push_data_o.addr1 = ADDR_W'(LAST_ENTRY - 1);
      push_data_o.mult  = sq7_q - (SQ_W'(LAST_ENTRY) << FRAC_BITS);
    end else begin
      push_data_o.addr0 = lpos[ADDR_W-1:0];
      push_data_o.addr1 = lpos[ADDR_W-1:0] + ADDR_W'(1);
      push_data_o.mult  = SQ_W'(fpos);
    end
  end

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reserved_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("front credit count above queue depth");

endmodule

// ----- sv/lsti_fifo.sv -----
// Queue between the front pipeline and the table back end.
module lsti_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lsti_pkg::q_entry_t push_data_i,
  input  logic               pop_i,
  output logic               valid_o,
  output lsti_pkg::q_entry_t data_o
);
  import lsti_pkg::*;

  q_entry_t              store_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] count_q;

  assign valid_o = (count_q != '0);
  assign data_o  = store_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      count_q <= count_q + FIFO_CNT_W'(push_i) - FIFO_CNT_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) store_q[wr_ptr_q] <= push_data_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < FIFO_CNT_W'(FIFO_DEPTH)) || pop_i)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("queue pop while empty");

endmodule

// ----- sv/lsti_back.sv -----
// Back end: table storage, interpolation multiply, clamp and result register.
module lsti_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  lsti_pkg::q_entry_t           q_data_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [lsti_pkg::VALUE_W-1:0] cross_section_o
);
  import lsti_pkg::*;

  logic [VALUE_W-1:0] table_mem [TABLE_ENTRIES];
  logic [VALUE_W-1:0] rd0_q, rd1_q;

  logic                en_b;
  logic                wr_ok;
  logic                b1_valid_q, b2_valid_q, out_valid_q;
  logic                b1_zero_q, b1_ext_q, b2_zero_q;
  logic [SQ_W-1:0]     b1_mult_q;

  logic signed [VALUE_W:0]   rd0_s, rd1_s, diff;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  b2_prod_q;
  logic [VALUE_W-1:0]        b2_base_q;
  logic signed [V_W-1:0]     v;
  logic [VALUE_W-1:0]        clamped;
  logic [VALUE_W-1:0]        out_q;

  // the whole back end holds while a finished result waits
  assign en_b  = !out_valid_q || out_ready_i;
  assign pop_o = q_valid_i && en_b;
  assign wr_ok = {1'b0, q_data_i.wr_idx} < (ENTRY_IDX_W+1)'(TABLE_ENTRIES);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      if (q_data_i.is_wr) begin
        if (wr_ok) table_mem[q_data_i.wr_idx[ADDR_W-1:0]] <= q_data_i.wr_val;
      end else begin
        rd0_q <= table_mem[q_data_i.addr0];
        rd1_q <= table_mem[q_data_i.addr1];
      end
      b1_zero_q <= q_data_i.zero;
      b1_ext_q  <= q_data_i.ext;
      b1_mult_q <= q_data_i.mult;
    end
  end

  assign rd0_s = signed'({1'b0, rd0_q});
  assign rd1_s = signed'({1'b0, rd1_q});
  assign diff  = b1_ext_q ? (rd0_s - rd1_s) : (rd1_s - rd0_s);
  assign prod  = PROD_W'(diff) * PROD_W'(signed'({1'b0, b1_mult_q}));

  // arithmetic shift gives the floor of the scaled step
  assign v = {{(V_W-(PROD_W-FRAC_BITS)){b2_prod_q[PROD_W-1]}},
              b2_prod_q[PROD_W-1:FRAC_BITS]}
           + {{(V_W-VALUE_W){1'b0}}, b2_base_q};

  always_comb begin
    if (b2_zero_q || v[V_W-1]) begin
      clamped = '0;
    end else if (v[V_W-2:VALUE_W] != '0) begin
      clamped = '1;
    end else begin
      clamped = v[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      b2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_b) begin
      b1_valid_q  <= pop_o && !q_data_i.is_wr;
      b2_valid_q  <= b1_valid_q;
      out_valid_q <= b2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      b2_prod_q <= prod;
      b2_base_q <= rd0_q;
      b2_zero_q <= b1_zero_q;
      out_q     <= clamped;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cross_section_o = out_q;

  a_low_energy_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_b && b2_valid_q && b2_zero_q) |=> (out_valid_q && out_q == '0))
    else $error("sub-eV query gave a nonzero result");

endmodule

// ----- sv/log_spaced_table_interpolator_unit.sv -----
// Throughput: one transaction per cycle while the output is not stalled; the log2 front
// pipeline and the table back end each take one item a cycle, the back end only while no
// finished result waits, and a 16-entry queue between them absorbs output stalls.
// Writes update the table in order with queries and produce no result.
// Reset clears all control state and loads index_scale with its default; the table
// contents are undefined until written.
module log_spaced_table_interpolator_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             cmd_i,
  input  logic [lsti_pkg::ENERGY_W-1:0]    energy_i,
  input  logic [lsti_pkg::ENTRY_IDX_W-1:0] entry_index_i,
  input  logic [lsti_pkg::VALUE_W-1:0]     entry_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [lsti_pkg::VALUE_W-1:0]     cross_section_o,
  input  logic                             cfg_we_i,
  input  logic [lsti_pkg::SCALE_W-1:0]     cfg_wdata_i
);
  import lsti_pkg::*;

  logic [SCALE_W-1:0] index_scale_q;
  logic               push, pop, q_valid;
  q_entry_t           push_data, q_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_scale_q <= SCALE_RESET;
    end else if (cfg_we_i) begin
      index_scale_q <= cfg_wdata_i;
    end
  end

  lsti_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .energy_i      (energy_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .index_scale_i (index_scale_q),
    .pop_i         (pop),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  lsti_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  lsti_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_data_i        (q_data),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cross_section_o (cross_section_o)
  );

endmodule
